[design/hbd_pkg.sv]
// Package for the HDLC byte deframer: framing codes, mode and result kinds,
// the result word struct and the FCS-16 byte update. No dependencies.
package hbd_pkg;

   // Default frame limit for the MAX_FRAME parameter of the top level.
   localparam int unsigned MAX_FRAME_DEFAULT = 256;

   // Framing and check constants.
   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_XOR   = 8'h20;
   localparam logic [15:0] FCS_INIT  = 16'hFFFF;
   localparam logic [15:0] FCS_GOOD  = 16'hF0B8;
   localparam logic [15:0] FCS_POLY  = 16'h8408;

   // Reset value of the max_length register.
   localparam logic [8:0]  MAX_LENGTH_RESET = 9'd256;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_FRAME = 2'd1,
      MODE_ESC   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_GOOD = 2'd1,
      KIND_BAD  = 2'd2,
      KIND_OVF  = 2'd3
   } kind_type;

   // One result word from the deframer core to the output stage.
   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data_byte;
   } result_type;

   // Reflected FCS-16 update over one byte, one bit per step.
   function automatic logic [15:0] fcs16_byte(input logic [15:0] fcs, input logic [7:0] b);
      logic [15:0] v;
      v = fcs ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (v[0]) begin
            v = (v >> 1) ^ FCS_POLY;
         end else begin
            v = v >> 1;
         end
      end
      return v;
   endfunction

endpackage

[design/hbd_core.sv]
// Deframer core: mode, byte count and running FCS registers with the
// per-byte unstuffing and check logic. Depends on hbd_pkg.
module hbd_core
   import hbd_pkg::*;
#(
   parameter int unsigned MAX_FRAME = MAX_FRAME_DEFAULT,
   localparam int unsigned LimitMax = (MAX_FRAME < 511) ? MAX_FRAME : 511,
   localparam int unsigned CntW     = $clog2(LimitMax + 2)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   input  logic [8:0]      max_length,
   output result_type      res,
   output logic [CntW-1:0] res_count
);

   localparam logic [16:0] MaxFrameExt = 17'(MAX_FRAME);

   mode_type        mode_ff, mode_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [15:0]     fcs_ff, fcs_in;

   logic [16:0] limit_ext;
   logic        over_limit;
   logic [7:0]  store_byte;
   logic [15:0] fcs_store;

   // The limit in force is max_length clamped to MAX_FRAME.
   always_comb begin
      if (17'(max_length) > MaxFrameExt) begin
         limit_ext = MaxFrameExt;
      end else begin
         limit_ext = 17'(max_length);
      end
   end

   assign over_limit = 17'(count_ff) > limit_ext;

   // An escaped byte is stored with bit 5 flipped.
   assign store_byte = (mode_ff == MODE_ESC) ? (rx_byte ^ ESC_XOR) : rx_byte;
   assign fcs_store  = fcs16_byte(fcs_ff, store_byte);

   // Next state and result for the byte being stepped.
   always_comb begin
      mode_in       = mode_ff;
      count_in      = count_ff;
      fcs_in        = fcs_ff;
      res.valid     = 1'b0;
      res.kind      = KIND_DATA;
      res.data_byte = 8'h00;
      if (step) begin
         case (mode_ff)
            MODE_FRAME: begin
               if (over_limit) begin
                  res.valid = 1'b1;
                  res.kind  = KIND_OVF;
                  mode_in   = MODE_IDLE;
               end else if (rx_byte == FLAG_BYTE) begin
                  res.valid = 1'b1;
                  res.kind  = (fcs_ff == FCS_GOOD) ? KIND_GOOD : KIND_BAD;
                  mode_in   = MODE_IDLE;
               end else if (rx_byte == ESC_BYTE) begin
                  mode_in = MODE_ESC;
               end else begin
                  res.valid     = 1'b1;
                  res.data_byte = store_byte;
                  count_in      = count_ff + 1'b1;
                  fcs_in        = fcs_store;
               end
            end
            MODE_ESC: begin
               if (rx_byte == FLAG_BYTE) begin
                  res.valid = 1'b1;
                  res.kind  = (fcs_ff == FCS_GOOD) ? KIND_GOOD : KIND_BAD;
                  mode_in   = MODE_IDLE;
               end else begin
                  res.valid     = 1'b1;
                  res.data_byte = store_byte;
                  count_in      = count_ff + 1'b1;
                  fcs_in        = fcs_store;
                  mode_in       = MODE_FRAME;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               if (rx_byte == FLAG_BYTE) begin
                  mode_in  = MODE_FRAME;
                  count_in = '0;
                  fcs_in   = FCS_INIT;
               end
            end
         endcase
      end
   end

   // Ends and aborts leave the count alone, so the next count is the reported one.
   assign res_count = count_in;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         fcs_ff   <= FCS_INIT;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         fcs_ff   <= fcs_in;
      end
   end

   // A byte seen in idle never produces a result.
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      step && mode_ff == MODE_IDLE |-> !res.valid)
      else $error("result produced while idle");

   // A flag inside a frame always closes it with a result.
   a_flag_closes: assert property (@(posedge clock) disable iff (reset)
      step && mode_ff != MODE_IDLE && rx_byte == FLAG_BYTE |-> res.valid && res.kind != KIND_DATA)
      else $error("flag inside frame did not close it");

   // No result without a stepped byte.
   a_no_step_no_result: assert property (@(posedge clock) disable iff (reset)
      !step |-> !res.valid)
      else $error("result without input byte");

   // Frame start resets the count and the FCS.
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      step && mode_ff == MODE_IDLE && rx_byte == FLAG_BYTE |=> count_ff == '0 && fcs_ff == FCS_INIT)
      else $error("frame start did not clear count or FCS");

endmodule

[design/hbd_out_stage.sv]
// Result register between the deframer core and the rsp_ channel.
// Depends on hbd_pkg.
module hbd_out_stage
   import hbd_pkg::*;
#(
   parameter int unsigned CNT_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  result_type       res,
   input  logic [CNT_W-1:0] res_count,
   output logic             advance,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [8:0]       rsp_frame_length
);

   logic             valid_ff;
   kind_type         kind_ff;
   logic [7:0]       data_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W+8:0] count_wide;

   // The register can take a new word when empty or being emptied now.
   assign advance = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= res.valid;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (advance && res.valid) begin
         kind_ff  <= res.kind;
         data_ff  <= res.data_byte;
         count_ff <= res_count;
      end
   end

   // Length is reported modulo 512.
   assign count_wide       = {9'd0, count_ff};
   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_frame_length = count_wide[8:0];

endmodule

[design/hdlc_byte_deframer_fcs16_top.sv]
// Top level of the async HDLC byte deframer with FCS-16 check.
// Depends on hbd_pkg, hbd_core and hbd_out_stage.
//
// One raw serial byte per word on req_, at most one result word per byte on
// rsp_: payload bytes after unstuffing, then a good/bad FCS verdict on the
// closing flag, or an overflow abort once the frame passes the length limit
// (max_length, clamped to MAX_FRAME). The block takes one byte every clock
// cycle while rsp_ is not stalled; a byte is registered in the input register
// and waits there until the result register can take a word; its result is
// then loaded into the result register, from which it is offered on rsp_.
// The FSM step and the bit-wise FCS-16 byte update sit together between
// those two registers. max_length is written through csr_wr_en/csr_wr_data
// and resets to 256.
module hdlc_byte_deframer_fcs16_top
   import hbd_pkg::*;
#(
   parameter int unsigned MAX_FRAME = MAX_FRAME_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [8:0] rsp_frame_length,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data
);

   localparam int unsigned LimitMax = (MAX_FRAME < 511) ? MAX_FRAME : 511;
   localparam int unsigned CntW     = $clog2(LimitMax + 2);

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic [8:0]      max_length_ff;
   logic            advance;
   logic            step;
   result_type      res;
   logic [CntW-1:0] res_count;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_wr_en) begin
         max_length_ff <= csr_wr_data;
      end
   end

   // Input register: holds while its word cannot move to the core.
   assign req_stall = in_valid_ff && !advance;
   assign step      = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   hbd_core #(
      .MAX_FRAME (MAX_FRAME)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .max_length (max_length_ff),
      .res        (res),
      .res_count  (res_count)
   );

   hbd_out_stage #(
      .CNT_W (CntW)
   ) u_out (
      .clock            (clock),
      .reset            (reset),
      .res              (res),
      .res_count        (res_count),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_length (rsp_frame_length)
   );

   // The input side only backs up when a result is held by a stalled output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // Only payload words carry a data byte.
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DATA |-> rsp_data_byte == 8'h00)
      else $error("data byte set on non-payload result");

   // A stalled input word stays in the input register.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && in_byte_ff == $past(in_byte_ff))
      else $error("input register lost a stalled word");

endmodule
